// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ADC sample ring.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/asrb_pkg.sv =====
// Package for the ADC sample ring: sizes, command codes and the stage record.
// Depends on nothing; used by adc_sample_ring_half_block_notify.
`timescale 1ns / 1ps
`default_nettype none

package asrb_pkg;

    localparam int RING_DEPTH  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int POS_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = POS_W + 1;
    localparam int DIV_CNT_W   = $clog2(POS_W);

    localparam logic [POS_W-1:0] HALF_MAX = POS_W'(RING_DEPTH / 2);

    typedef enum logic [1:0] {
        MODE_CONVERT = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef struct packed {
        logic             notify;
        logic             overrun;
        logic             ready;
        logic [POS_W-1:0] start;
        logic [CNT_W-1:0] count;
        logic             is_read;
    } stage_t;

endpackage

`default_nettype wire

// ===== rtl/adc_sample_ring_half_block_notify.sv =====
// ADC sample ring with half-block notification: top level.
// Depends on asrb_pkg and assert_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | mode, end_of_conversion, window_compare, sample,
//          |                      | read_index
//  out     | out_valid / out_stall| conversion_notify, overrun, block_ready,
//          |                      | block_start, block_count, read_data
//  cfg     | cfg_write            | cfg_data (half_size)
//
// One item per cycle while in_stall is low; a transfer passes through the read stage
// (with the registered read port of the sample memory), then through the output register.
// A half_size write stalls input in its write cycle and, if the saturated value is nonzero,
// while a bit-serial unit reduces the read position modulo the ring length.
// Reset clears positions, counts, half_size and pipeline valids; the memory is not cleared.
// Output stall backs up through the read stage into in_stall without losing items.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adc_sample_ring_half_block_notify (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_write,
    input  wire logic [asrb_pkg::POS_W-1:0]          cfg_data,
    // input channel
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic [1:0]                          mode,
    input  wire logic                                end_of_conversion,
    input  wire logic                                window_compare,
    input  wire logic [asrb_pkg::SAMPLE_BITS-1:0]    sample,
    input  wire logic [asrb_pkg::POS_W-1:0]          read_index,
    // output channel
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic                                conversion_notify,
    output      logic                                overrun,
    output      logic                                block_ready,
    output      logic [asrb_pkg::POS_W-1:0]          block_start,
    output      logic [asrb_pkg::CNT_W-1:0]          block_count,
    output      logic [asrb_pkg::SAMPLE_BITS-1:0]    read_data
);

    // ring state
    logic [asrb_pkg::POS_W-1:0] half_reg, half_next;
    logic [asrb_pkg::POS_W-1:0] wp_reg, wp_next;
    logic [asrb_pkg::POS_W-1:0] rp_reg, rp_next;
    logic [asrb_pkg::POS_W-1:0] rpm_reg, rpm_next;
    logic [asrb_pkg::CNT_W-1:0] pc_reg, pc_next;
    logic [asrb_pkg::POS_W-1:0] ps_reg, ps_next;

    // remainder unit
    logic                           div_busy_reg, div_busy_next;
    logic [asrb_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [asrb_pkg::POS_W-1:0]     div_rem_reg, div_rem_next;
    logic [asrb_pkg::POS_W-1:0]     div_num_reg, div_num_next;
    logic [asrb_pkg::CNT_W-1:0]     div_shift;
    logic [asrb_pkg::CNT_W-1:0]     div_step;

    // pipeline
    logic              s1_valid_reg, s1_valid_next;
    asrb_pkg::stage_t  s1_reg, s1_next;
    logic              out_valid_reg, out_valid_next;
    asrb_pkg::stage_t  out_reg, out_next;
    logic [asrb_pkg::SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    // sample memory
    logic [asrb_pkg::SAMPLE_BITS-1:0] sample_mem [asrb_pkg::RING_DEPTH];
    logic [asrb_pkg::SAMPLE_BITS-1:0] mem_rdata_reg;
    logic                             mem_we;
    logic                             mem_re;

    // datapath intermediates
    logic                        accept;
    logic                        s1_advance;
    logic [asrb_pkg::CNT_W-1:0]  ring_len;
    logic [asrb_pkg::CNT_W-1:0]  wp_inc;
    logic [asrb_pkg::POS_W-1:0]  wp_wrap;
    logic [asrb_pkg::CNT_W-1:0]  wait_sum;
    logic [asrb_pkg::CNT_W-1:0]  waiting;
    logic [asrb_pkg::CNT_W-1:0]  rel_sum;
    logic [asrb_pkg::POS_W-1:0]  rel_pos;
    logic [asrb_pkg::POS_W-1:0]  cfg_sat;

    // handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = div_busy_reg || cfg_write || (s1_valid_reg && !s1_advance);
    assign accept     = in_valid && !in_stall;

    // shared arithmetic
    assign ring_len = {half_reg, 1'b0};
    assign wp_inc   = {1'b0, wp_reg} + asrb_pkg::CNT_W'(1);
    assign wp_wrap  = (wp_inc >= ring_len) ? '0 : wp_inc[asrb_pkg::POS_W-1:0];
    assign wait_sum = {1'b0, wp_wrap} + ring_len - {1'b0, rpm_reg};
    assign waiting  = (wait_sum >= ring_len) ? (wait_sum - ring_len) : wait_sum;
    assign rel_sum  = {1'b0, ps_reg} + pc_reg;
    assign rel_pos  = (rel_sum >= ring_len) ? '0 : rel_sum[asrb_pkg::POS_W-1:0];
    assign cfg_sat  = (cfg_data > asrb_pkg::HALF_MAX) ? asrb_pkg::HALF_MAX : cfg_data;

    // one restoring step of read position modulo ring length
    assign div_shift = {div_rem_reg, div_num_reg[asrb_pkg::POS_W-1]};
    assign div_step  = (div_shift >= ring_len) ? (div_shift - ring_len) : div_shift;

    // decode the command and update the ring state
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        rpm_next = rpm_reg;
        pc_next  = pc_reg;
        ps_next  = ps_reg;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        s1_next  = s1_reg;
        if (accept)
        begin
            s1_next.notify  = 1'b0;
            s1_next.overrun = 1'b0;
            s1_next.ready   = 1'b0;
            s1_next.is_read = 1'b0;
            unique case (asrb_pkg::mode_t'(mode))
                asrb_pkg::MODE_CONVERT:
                begin
                    if (half_reg == '0)
                    begin
                        s1_next.notify = end_of_conversion | window_compare;
                    end
                    else if (end_of_conversion)
                    begin
                        mem_we          = 1'b1;
                        wp_next         = wp_wrap;
                        s1_next.overrun = (wp_wrap == rp_reg);
                        if (pc_reg == '0 && waiting >= {1'b0, half_reg})
                        begin
                            pc_next       = waiting;
                            ps_next       = rp_reg;
                            s1_next.ready = 1'b1;
                        end
                    end
                end
                asrb_pkg::MODE_RELEASE:
                begin
                    rp_next  = rel_pos;
                    rpm_next = rel_pos;
                    pc_next  = '0;
                end
                asrb_pkg::MODE_CLEAR:
                begin
                    rp_next  = '0;
                    wp_next  = '0;
                    rpm_next = '0;
                    pc_next  = '0;
                end
                asrb_pkg::MODE_READ:
                begin
                    mem_re          = 1'b1;
                    s1_next.is_read = 1'b1;
                end
            endcase
            s1_next.start = ps_next;
            s1_next.count = pc_next;
        end
        // finish the remainder pass
        if (div_busy_reg && div_cnt_reg == '0)
        begin
            rpm_next = div_step[asrb_pkg::POS_W-1:0];
        end
        if (cfg_write && cfg_sat == '0)
        begin
            rpm_next = '0;
        end
    end

    // configuration write and remainder sequencing
    always_comb
    begin
        half_next     = half_reg;
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        div_rem_next  = div_rem_reg;
        div_num_next  = div_num_reg;
        if (div_busy_reg)
        begin
            div_rem_next = div_step[asrb_pkg::POS_W-1:0];
            div_num_next = {div_num_reg[asrb_pkg::POS_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg - asrb_pkg::DIV_CNT_W'(1);
            if (div_cnt_reg == '0)
            begin
                div_busy_next = 1'b0;
            end
        end
        if (cfg_write)
        begin
            half_next     = cfg_sat;
            div_busy_next = (cfg_sat != '0);
            div_cnt_next  = asrb_pkg::DIV_CNT_W'(asrb_pkg::POS_W - 1);
            div_rem_next  = '0;
            div_num_next  = rp_reg;
        end
    end

    // advance the pipeline
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
            out_next       = s1_reg;
            out_data_next  = s1_reg.is_read ? mem_rdata_reg : '0;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            rpm_reg       <= '0;
            pc_reg        <= '0;
            ps_reg        <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            half_reg      <= half_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            rpm_reg       <= rpm_next;
            pc_reg        <= pc_next;
            ps_reg        <= ps_next;
            div_busy_reg  <= div_busy_next;
            div_cnt_reg   <= div_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        div_rem_reg  <= div_rem_next;
        div_num_reg  <= div_num_next;
        s1_reg       <= s1_next;
        out_reg      <= out_next;
        out_data_reg <= out_data_next;
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[wp_reg] <= sample;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= sample_mem[read_index];
        end
    end

    // drive the output ports
    assign out_valid         = out_valid_reg;
    assign conversion_notify = out_reg.notify;
    assign overrun           = out_reg.overrun;
    assign block_ready       = out_reg.ready;
    assign block_start       = out_reg.start;
    assign block_count       = out_reg.count;
    assign read_data         = out_data_reg;

    // checks
    `ASSERT_SAME(a_rpm_in_ring, !div_busy_reg && half_reg != '0, {1'b0, rpm_reg} < ring_len, "reduced read position outside ring")
    `ASSERT_SAME(a_ready_has_count, out_valid_reg && out_reg.ready, out_reg.count != '0, "block published with zero count")
    `ASSERT_SAME(a_busy_stalls, div_busy_reg, in_stall, "transfer taken during remainder pass")
    `ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg, "accepted transfer lost before read stage")

endmodule

`default_nettype wire
